[hw/rtl/bsfd_pkg.sv]
`timescale 1ns / 1ps

package bsfd_pkg;

    localparam int FRAME_CAPACITY = 32;
    localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
    localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_W          = 8;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START  = 2'd0,
        REG_STOP   = 2'd1,
        REG_ESCAPE = 2'd2
    } cfg_reg_t;

    localparam byte_t START_RESET  = 8'd2;
    localparam byte_t STOP_RESET   = 8'd3;
    localparam byte_t ESCAPE_RESET = 8'd16;

    // Handoff from the byte parser to the frame emitter when a frame closes.
    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] count;
        logic             ovf;
        byte_t            command;
    } emit_req_t;

endpackage

[hw/rtl/byte_stuffed_frame_decoder.sv]
`timescale 1ns / 1ps

// Start/stop/escape byte-stuffing deframer.
// Input channel s_*: one raw link byte per word (s_in_byte), valid/ready.
// Output channel m_*: one word per payload byte of a closed frame, each with
// the frame's command byte, the overflow flag and last on the final word.
// A frame holding only its command gives one word with m_has_payload low.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, index 0 start, 1 stop,
// 2 escape; writes take effect next cycle. Writes are for idle only; the block itself does not enforce it.
// Input bytes are taken only while no frame is being emitted.
// The first output word is valid in the cycle after the closing stop for a
// command-only frame and after a RAM read state (ST_RD) otherwise; each
// further payload word goes through a RAM read state and an output state
// (ST_OUT), set by the single read port of the frame buffer.
// s_ready is low from the closing stop until the last word is taken;
// a stalled receiver simply holds the output word and the input stays off.
// Reset (aresetn low, synchronous) closes any frame, clears the escape
// state and restores the default start/stop/escape values 2/3/16.

module byte_stuffed_frame_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsfd_pkg::CFG_W-1:0]      cfg_wdata,
    // raw link bytes
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bsfd_pkg::byte_t                 s_in_byte,
    // decoded frame words
    output logic                            m_valid,
    input  logic                            m_ready,
    output bsfd_pkg::byte_t                 m_command,
    output bsfd_pkg::byte_t                 m_payload_byte,
    output logic                            m_has_payload,
    output logic                            m_last,
    output logic                            m_overflow
);

    import bsfd_pkg::*;

    logic              accept;
    logic              emit_idle;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    byte_t             mem_wdata, mem_rdata;
    emit_req_t         req;

    // parser only runs while the emitter is not walking the buffer
    assign s_ready = emit_idle;
    assign accept  = s_valid && s_ready;

    bsfd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_in_byte),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .req       (req)
    );

    // frame buffer, contents undefined until written in the current frame
    bsfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bsfd_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .idle           (emit_idle),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command      (m_command),
        .m_payload_byte (m_payload_byte),
        .m_has_payload  (m_has_payload),
        .m_last         (m_last),
        .m_overflow     (m_overflow)
    );

    // buffer is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("frame buffer written during emission");

    // a frame close always hands off to an idle emitter
    a_go_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.go |=> !s_ready)
        else $error("input still open after frame close");

endmodule

[hw/rtl/bsfd_ram.sv]
`timescale 1ns / 1ps

module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bsfd_parse.sv]
`timescale 1ns / 1ps

module bsfd_parse (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsfd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                accept,
    input  bsfd_pkg::byte_t                     in_byte,
    output logic                                mem_we,
    output logic [bsfd_pkg::ADDR_W-1:0]         mem_waddr,
    output bsfd_pkg::byte_t                     mem_wdata,
    output bsfd_pkg::emit_req_t                 req
);

    import bsfd_pkg::*;

    byte_t            start_reg, stop_reg, escape_reg;
    byte_t            cmd_reg, cmd_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;
    logic             inframe_reg, inframe_next;
    logic             ovf_reg, ovf_next;

    logic is_esc, is_start, is_stop, is_other, store, full;

    // escape wins over start, start over stop
    assign is_esc   = (in_byte == escape_reg);
    assign is_start = !is_esc && (in_byte == start_reg);
    assign is_stop  = !is_esc && !is_start && (in_byte == stop_reg);
    assign is_other = !is_esc && !is_start && !is_stop;
    assign full     = (fill_reg == CNT_W'(FRAME_CAPACITY));

    assign store = accept && inframe_reg &&
                   (((is_esc || is_start || is_stop) && pend_reg) ||
                    (is_other && !pend_reg));

    assign mem_we    = store && !full;
    assign mem_waddr = fill_reg[ADDR_W-1:0];
    assign mem_wdata = in_byte;

    always_comb begin
        fill_next    = fill_reg;
        pend_next    = pend_reg;
        inframe_next = inframe_reg;
        ovf_next     = ovf_reg;
        cmd_next     = cmd_reg;
        req          = '0;
        req.count    = fill_reg;
        req.ovf      = ovf_reg;
        req.command  = cmd_reg;
        if (store) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                fill_next = fill_reg + CNT_W'(1);
                if (fill_reg == '0) begin
                    cmd_next = in_byte;
                end
            end
        end
        if (accept) begin
            priority if (is_esc) begin
                pend_next = !pend_reg;
            end else if (is_start || is_stop) begin
                if (pend_reg) begin
                    pend_next = 1'b0;
                end else if (is_start) begin
                    fill_next    = '0;
                    ovf_next     = 1'b0;
                    inframe_next = 1'b1;
                end else if (inframe_reg) begin
                    req.go       = (fill_reg != '0);
                    inframe_next = 1'b0;
                    fill_next    = '0;
                    ovf_next     = 1'b0;
                end
            end else begin
                if (inframe_reg && pend_reg) begin
                    pend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_RESET;
            stop_reg    <= STOP_RESET;
            escape_reg  <= ESCAPE_RESET;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            inframe_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_START:  start_reg  <= cfg_wdata;
                    REG_STOP:   stop_reg   <= cfg_wdata;
                    REG_ESCAPE: escape_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            inframe_reg <= inframe_next;
            ovf_reg     <= ovf_next;
        end
        cmd_reg <= cmd_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(FRAME_CAPACITY))
        else $error("fill count beyond capacity");

endmodule

[hw/rtl/bsfd_emit.sv]
`timescale 1ns / 1ps

module bsfd_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bsfd_pkg::emit_req_t         req,
    output logic                        idle,
    output logic                        mem_re,
    output logic [bsfd_pkg::ADDR_W-1:0] mem_raddr,
    input  bsfd_pkg::byte_t             mem_rdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bsfd_pkg::byte_t             m_command,
    output bsfd_pkg::byte_t             m_payload_byte,
    output logic                        m_has_payload,
    output logic                        m_last,
    output logic                        m_overflow
);

    import bsfd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg, valid_reg, last_reg, haspay_reg;
    byte_t            cmd_reg;

    assign idle      = (state_reg == ST_IDLE);
    assign mem_re    = (state_reg == ST_RD);
    assign mem_raddr = k_reg;

    // payload comes straight off the RAM's read register, held while in ST_OUT
    assign m_valid        = valid_reg;
    assign m_command      = cmd_reg;
    assign m_payload_byte = haspay_reg ? mem_rdata : '0;
    assign m_has_payload  = haspay_reg;
    assign m_last         = last_reg;
    assign m_overflow     = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.go) begin
                        cnt_reg <= req.count;
                        ovf_reg <= req.ovf;
                        cmd_reg <= req.command;
                        if (req.count == CNT_W'(1)) begin
                            haspay_reg <= 1'b0;
                            last_reg   <= 1'b1;
                            valid_reg  <= 1'b1;
                            state_reg  <= ST_OUT;
                        end else begin
                            haspay_reg <= 1'b1;
                            k_reg      <= ADDR_W'(1);
                            state_reg  <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    valid_reg <= 1'b1;
                    last_reg  <= ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + ADDR_W'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_read_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> (CNT_W'(k_reg) < cnt_reg))
        else $error("read past end of stored frame");

    a_cmd_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !haspay_reg) |-> last_reg)
        else $error("command-only word without last");

    a_gap_after_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && !last_reg) |=> (!valid_reg && state_reg == ST_RD))
        else $error("next payload word must go through a read cycle");

endmodule

[tb/deframe_checker.sv]
`timescale 1ns / 1ps

// Watches both channels and the config port, decodes the link bytes on its
// own and compares every output word with the oldest predicted one.
module deframe_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsfd_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  bsfd_pkg::byte_t                s_in_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  bsfd_pkg::byte_t                m_command,
    input  bsfd_pkg::byte_t                m_payload_byte,
    input  logic                           m_has_payload,
    input  logic                           m_last,
    input  logic                           m_overflow,
    output int                             mismatches,
    output int                             words_pending,
    output int                             words_checked,
    output int                             frames_closed,
    output int                             frames_overflowed
);

    import bsfd_pkg::*;

    typedef struct packed {
        byte_t command;
        byte_t payload;
        logic  has_payload;
        logic  last;
        logic  ovf;
    } frame_word_t;

    frame_word_t expected_words[$];

    byte_t start_val, stop_val, esc_val;
    byte_t frame_buf [FRAME_CAPACITY];
    int    fill;
    bit    esc_pend, open, dropped;

    function automatic void keep_byte(byte_t b);
        if (!open) return;
        if (fill < FRAME_CAPACITY) begin
            frame_buf[fill] = b;
            fill++;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    // one link byte through the deframer; queues the words a closing stop yields
    function automatic void decode_link_byte(byte_t b);
        frame_word_t w;
        if (b == esc_val) begin
            if (esc_pend) keep_byte(b);
            esc_pend = !esc_pend;
        end else if (b == start_val) begin
            if (esc_pend) begin
                keep_byte(b);
                esc_pend = 1'b0;
            end else begin
                fill    = 0;
                dropped = 1'b0;
                open    = 1'b1;
            end
        end else if (b == stop_val) begin
            if (esc_pend) begin
                keep_byte(b);
                esc_pend = 1'b0;
            end else if (open) begin
                if (fill == 1) begin
                    w = '{frame_buf[0], 8'h00, 1'b0, 1'b1, dropped};
                    expected_words.insert(expected_words.size(), w);
                end else begin
                    for (int k = 1; k < fill; k++) begin
                        w = '{frame_buf[0], frame_buf[k], 1'b1, (k + 1 == fill), dropped};
                        expected_words.insert(expected_words.size(), w);
                    end
                end
                if (fill > 0) frames_closed++;
                if (fill > 0 && dropped) frames_overflowed++;
                open    = 1'b0;
                fill    = 0;
                dropped = 1'b0;
            end
        end else if (open) begin
            if (esc_pend) esc_pend = 1'b0;
            else keep_byte(b);
        end
    endfunction

    always @(posedge aclk) begin
        frame_word_t want;
        if (!aresetn) begin
            start_val         = START_RESET;
            stop_val          = STOP_RESET;
            esc_val           = ESCAPE_RESET;
            fill              = 0;
            esc_pend          = 1'b0;
            open              = 1'b0;
            dropped           = 1'b0;
            mismatches        = 0;
            words_checked     = 0;
            frames_closed     = 0;
            frames_overflowed = 0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] extra word: cmd %02h data %02h has %0b last %0b ovf %0b",
                                 $realtime, m_command, m_payload_byte, m_has_payload,
                                 m_last, m_overflow);
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (m_command !== want.command || m_payload_byte !== want.payload ||
                        m_has_payload !== want.has_payload || m_last !== want.last ||
                        m_overflow !== want.ovf) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("[%0t] word mismatch: want ", $realtime);
                            $write("cmd %02h data %02h has %0b last %0b ovf %0b",
                                   want.command, want.payload, want.has_payload,
                                   want.last, want.ovf);
                            $display(", got cmd %02h data %02h has %0b last %0b ovf %0b",
                                     m_command, m_payload_byte, m_has_payload,
                                     m_last, m_overflow);
                        end
                    end
                    words_checked++;
                end
            end
            if (s_valid && s_ready) decode_link_byte(s_in_byte);
            // a write counts from the next cycle on
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START:  start_val = cfg_wdata;
                    REG_STOP:   stop_val  = cfg_wdata;
                    REG_ESCAPE: esc_val   = cfg_wdata;
                    default:    ;
                endcase
            end
        end
        words_pending = expected_words.size();
    end

endmodule

[tb/byte_stuffed_frame_decoder_tb.sv]
`timescale 1ns / 1ps

// Drives raw link bytes and config writes into the deframer, throttles the
// output side, and gives the verdict from the checker's mismatch count.
module byte_stuffed_frame_decoder_tb;

    import bsfd_pkg::*;

    // index past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    byte_t                s_in_byte;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    byte_t                m_command;
    byte_t                m_payload_byte;
    logic                 m_has_payload;
    logic                 m_last;
    logic                 m_overflow;

    int mismatches, words_pending, words_checked, frames_closed, frames_overflowed;

    // current framing bytes, used to stuff outgoing payload
    byte_t cur_start = START_RESET;
    byte_t cur_stop  = STOP_RESET;
    byte_t cur_esc   = ESCAPE_RESET;

    int burst_left  = 0;
    int bytes_sent  = 0;
    int frame_bytes = 0;   // bytes that went into frames (ignored ones excluded)
    int settings    = 1;
    int cycle_count = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    // directed opening, default framing 02/03/10:
    //   extreme cmd/data, command-only frame, empty frame,
    //   escaped start/stop/escape plus escape-then-ordinary drop,
    //   stop and escaped start outside a frame, restart mid-frame
    byte_t link_script [30] = '{
        8'h02, 8'h00, 8'hFF, 8'h03,
        8'h02, 8'hAA, 8'h03,
        8'h02, 8'h03,
        8'h02, 8'h41, 8'h10, 8'h02, 8'h10, 8'h03, 8'h10, 8'h10, 8'h10, 8'h77,
        8'h88, 8'h03,
        8'h03, 8'h10, 8'h02, 8'h5A,
        8'h02, 8'h11, 8'h02, 8'h33, 8'h03
    };

    byte_stuffed_frame_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command      (m_command),
        .m_payload_byte (m_payload_byte),
        .m_has_payload  (m_has_payload),
        .m_last         (m_last),
        .m_overflow     (m_overflow)
    );

    deframe_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command         (m_command),
        .m_payload_byte    (m_payload_byte),
        .m_has_payload     (m_has_payload),
        .m_last            (m_last),
        .m_overflow        (m_overflow),
        .mismatches        (mismatches),
        .words_pending     (words_pending),
        .words_checked     (words_checked),
        .frames_closed     (frames_closed),
        .frames_overflowed (frames_overflowed)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, words_pending);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: stall pattern switches among always-ready, coin flip,
    // periodic and mostly-stalled at random intervals
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= (cycle_count % 4) != 0;
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic bit is_special(byte_t b);
        return b == cur_start || b == cur_stop || b == cur_esc;
    endfunction

    // payload value biased toward the framing bytes
    function automatic byte_t pick_data();
        case ($urandom_range(0, 9))
            0:       return cur_start;
            1:       return cur_stop;
            2:       return cur_esc;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic byte_t pick_ordinary();
        byte_t b;
        for (int tries = 0; tries < 64; tries++) begin
            b = byte_t'($urandom_range(0, 255));
            if (!is_special(b)) return b;
        end
        return b;
    endfunction

    // caller sits at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input byte_t b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        bytes_sent++;
    endtask

    // stuffed data byte
    task automatic send_data(input byte_t b);
        if (is_special(b)) send_byte(cur_esc);
        send_byte(b);
    endtask

    task automatic send_frame(input int len);
        send_byte(cur_start);
        for (int i = 0; i < len; i++) send_data(pick_data());
        send_byte(cur_stop);
        frame_bytes += len + 2;
    endtask

    // hold the sender until every predicted word is out
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (words_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // only called with the block drained
    task automatic set_config(input byte_t st, input byte_t sp, input byte_t es,
                              input bit touch_spare);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START;
        cfg_wdata <= st;
        @(negedge aclk);
        cfg_index <= REG_STOP;
        cfg_wdata <= sp;
        @(negedge aclk);
        cfg_index <= REG_ESCAPE;
        cfg_wdata <= es;
        @(negedge aclk);
        if (touch_spare) begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= byte_t'($urandom_range(0, 255));
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        cur_start = st;
        cur_stop  = sp;
        cur_esc   = es;
        settings++;
    endtask

    // mostly well-formed frames, the rest noise and broken sequences
    task automatic random_traffic(input int budget);
        int stop_at;
        int len;
        stop_at = frame_bytes + budget;
        while (frame_bytes < stop_at) begin
            if ($urandom_range(0, 19) == 0) drain();
            if ($urandom_range(0, 9) < 7) begin
                // long frames, most of them running past capacity
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(0, 8);
                send_frame(len);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        // raw noise
                        len = $urandom_range(1, 5);
                        for (int i = 0; i < len; i++) send_byte(pick_data());
                    end
                    1: begin
                        // truncated frame, left open without a closing stop
                        len = $urandom_range(1, 6);
                        send_byte(cur_start);
                        for (int i = 0; i < len; i++) send_data(pick_data());
                        frame_bytes += len + 1;
                    end
                    2: begin
                        // escape ahead of an ordinary byte drops that byte
                        send_byte(cur_start);
                        send_data(pick_data());
                        send_byte(cur_esc);
                        send_byte(pick_ordinary());
                        send_data(pick_data());
                        send_byte(cur_stop);
                        frame_bytes += 6;
                    end
                    default: begin
                        // escaped start and bare stop outside a frame
                        send_byte(cur_esc);
                        send_byte(cur_start);
                        send_byte(cur_stop);
                    end
                endcase
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_START;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_in_byte = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 30; i++) send_byte(link_script[i]);
        drain();

        random_traffic(40);
        drain();
        set_config(8'h00, 8'hFF, 8'h80, 1'b0);
        random_traffic(35);
        drain();
        set_config(8'hFF, 8'h00, 8'h01, 1'b0);
        random_traffic(35);
        drain();
        // start equals stop: frames open but never close
        set_config(8'h55, 8'h55, 8'hAA, 1'b1);
        random_traffic(15);
        for (int p = 0; p < 2; p++) begin
            drain();
            set_config(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                       byte_t'($urandom_range(0, 255)), 1'b1);
            random_traffic(25);
        end

        drain();
        repeat (16) @(negedge aclk);
        $display("sent %0d link bytes over %0d framing settings", bytes_sent, settings);
        $display("checked %0d words from %0d frames, %0d of them past capacity",
                 words_checked, frames_closed, frames_overflowed);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bsfd_pkg.sv
hw/rtl/bsfd_ram.sv
hw/rtl/bsfd_parse.sv
hw/rtl/bsfd_emit.sv
hw/rtl/byte_stuffed_frame_decoder.sv
tb/deframe_checker.sv
tb/byte_stuffed_frame_decoder_tb.sv
